FILE: rtl/ic2d_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ic2d_pkg: shared types and constants of the 2D convolution core
// Request and response layouts, register indexes, the controller states and
// the control bundle that drives the row cells.
// ----------------------------------------------------------------------------
package ic2d_pkg;

   // Default sizes of the core.
   localparam int MAX_KERNEL_DEF = 5;
   localparam int MAX_COLS_DEF   = 1024;
   localparam int MAX_ROWS_DEF   = 1024;
   localparam int CHANNELS_DEF   = 3;
   localparam int COEF_FRAC_DEF  = 8;

   // Fixed widths.
   localparam int ACC_W  = 32;
   localparam int COEF_W = 16;
   localparam int SEL_W  = 3;
   localparam int CFG_W  = 11;
   localparam int CMP_W  = 16;
   localparam int STEP_W = 3;

   // Request kinds.
   localparam logic REQ_COEF  = 1'b0;
   localparam logic REQ_PIXEL = 1'b1;

   // Register reset values.
   localparam logic [CFG_W-1:0] FRAME_COLS_RST  = 11'd1024;
   localparam logic [CFG_W-1:0] FRAME_ROWS_RST  = 11'd1024;
   localparam logic [CFG_W-1:0] OUT_ROWS_RST    = 11'd1;
   localparam logic [CFG_W-1:0] OUT_COLS_RST    = 11'd1;
   localparam logic [2:0]       KERNEL_SIZE_RST = 3'd3;
   localparam logic [2:0]       STRIDE_RST      = 3'd1;

   // Clamp limit of a result sample.
   localparam int PIX_MAX = 255;

   typedef enum logic [2:0] {
      CSR_FRAME_COLS  = 3'd0,
      CSR_FRAME_ROWS  = 3'd1,
      CSR_OUT_ROWS    = 3'd2,
      CSR_OUT_COLS    = 3'd3,
      CSR_KERNEL_SIZE = 3'd4,
      CSR_STRIDE      = 3'd5
   } ic2d_csr_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_READ,
      ST_SHIFT,
      ST_MAC,
      ST_SUM,
      ST_DONE
   } ic2d_state_type;

   typedef struct packed {
      logic               req_type;
      logic [2:0]         coef_row;
      logic [2:0]         coef_col;
      logic signed [15:0] coef_value;
      logic [7:0]         pixel_ch0;
      logic [7:0]         pixel_ch1;
      logic [7:0]         pixel_ch2;
   } ic2d_req_type;

   typedef struct packed {
      logic [7:0] out_ch0;
      logic [7:0] out_ch1;
      logic [7:0] out_ch2;
      logic [9:0] out_row;
      logic [9:0] out_col;
      logic       frame_end;
   } ic2d_rsp_type;

   typedef struct packed {
      logic shift;
      logic mac_clear;
      logic mac_en;
      logic sum_shift;
   } ic2d_cell_ctl_type;

endpackage

FILE: rtl/ic2d_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ic2d_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module ic2d_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/ic2d_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ic2d_div: bit-serial divider by a small stride
// Restoring division of an unsigned word by a 3-bit divisor, one quotient
// bit per cycle.
// ----------------------------------------------------------------------------
module ic2d_div #(
   parameter int DW = 10
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [DW-1:0] dividend,
   input  logic [2:0]    divisor,
   output logic          busy,
   output logic [DW-1:0] quotient,
   output logic [2:0]    remainder
);

   localparam int CNT_W = $clog2(DW + 1);

   logic [DW-1:0]    work_ff, work_in;
   logic [2:0]       rem_ff, rem_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic [3:0]       trial;
   logic             fits;

   // One restoring step: bring down the next dividend bit and try the divisor.
   always_comb begin
      trial   = {rem_ff, work_ff[DW-1]};
      fits    = trial >= {1'b0, divisor};
      work_in = work_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         work_in = dividend;
         rem_in  = 3'd0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         work_in = {work_ff[DW-2:0], fits};
         rem_in  = fits ? 3'(trial - {1'b0, divisor}) : trial[2:0];
         cnt_in  = cnt_ff + 1'b1;
         busy_in = cnt_ff != CNT_W'(DW - 1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      work_ff <= work_in;
      rem_ff  <= rem_in;
   end

   assign busy      = busy_ff;
   assign quotient  = work_ff;
   assign remainder = rem_ff;

endmodule

FILE: rtl/ic2d_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ic2d_cell: one window row of the convolution
// Holds one row of the pixel window, multiplies its taps by the kernel row
// one column per cycle, and hands its partial sums down the chain.
// ----------------------------------------------------------------------------
module ic2d_cell import ic2d_pkg::*; #(
   parameter int MAX_KERNEL = MAX_KERNEL_DEF,
   parameter int CHANNELS   = CHANNELS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  ic2d_cell_ctl_type                ctl,
   input  logic [8*CHANNELS-1:0]            shift_pix,
   input  logic [SEL_W-1:0]                 col_sel,
   input  logic signed [COEF_W-1:0]         coef,
   input  logic                             row_used,
   input  logic [CHANNELS-1:0][ACC_W-1:0]   acc_in,
   output logic [CHANNELS-1:0][ACC_W-1:0]   acc_out
);

   localparam int PIX_W = 8 * CHANNELS;
   localparam int KW    = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;

   logic [PIX_W-1:0]        win_ff [MAX_KERNEL];
   logic [PIX_W-1:0]        tap;
   logic signed [ACC_W-1:0] acc_ff [CHANNELS];

   // Window row: shifts left, the new pixel enters on the right.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < MAX_KERNEL; j++) begin
            win_ff[j] <= '0;
         end
      end else if (ctl.shift) begin
         for (int j = 0; j < MAX_KERNEL - 1; j++) begin
            win_ff[j] <= win_ff[j + 1];
         end
         win_ff[MAX_KERNEL-1] <= shift_pix;
      end
   end

   assign tap = win_ff[col_sel[KW-1:0]];

   // Per-channel multiply-accumulate and hand-off of the partial sums.
   for (genvar n = 0; n < CHANNELS; n++) begin : g_lane
      logic signed [8+COEF_W:0] prod;
      logic signed [ACC_W-1:0]  acc_in_lane;

      assign prod        = $signed({1'b0, tap[8*n +: 8]}) * coef;
      assign acc_in_lane = $signed(acc_in[n]);
      assign acc_out[n]  = acc_ff[n];

      always_ff @(posedge clock) begin
         if (ctl.mac_clear) begin
            acc_ff[n] <= '0;
         end else if (ctl.mac_en && row_used) begin
            acc_ff[n] <= acc_ff[n] + ACC_W'(prod);
         end else if (ctl.sum_shift) begin
            acc_ff[n] <= acc_in_lane;
         end
      end
   end

endmodule

FILE: rtl/image_convolution_2d_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// image_convolution_2d_core: strided K x K convolution of a 3-channel image
// Streams a zero-padded raster image through line stores and a window of
// row cells and emits clamped filter sums at strided window positions.
// ----------------------------------------------------------------------------
// Usage:
//  The req_ channel carries one request per handshake: a kernel coefficient
//  (taken only at the start of a frame) or one padded pixel in raster order.
//  The rsp_ channel returns at most one result per pixel request: three
//  clamped channel sums, the output row and column and an end-of-frame flag.
//  The csr_ channel writes the frame and filter registers; write it only
//  while no request is in flight.
//  A coefficient request is taken in the idle state and leaves the controller
//  idle. A pixel request starts the bit-serial stride dividers, waits for them,
//  reads the column of the older rows from the line stores, shifts the window
//  and returns to idle if it completes no window. A pixel that produces a
//  result goes on with the column-serial multiply, the sum down the cell chain
//  and the output load. A new request is taken only in the idle state.
//  The result waits in an output register; the next request is taken while it
//  waits, and only a pixel that produces a new result stalls until the held
//  one has been taken.
//  Reset clears the kernel, the window, the position counters and the
//  registers; line store contents are undefined until written by a frame.
// ----------------------------------------------------------------------------
module image_convolution_2d_core import ic2d_pkg::*; #(
   parameter int MAX_KERNEL = MAX_KERNEL_DEF,
   parameter int MAX_COLS   = MAX_COLS_DEF,
   parameter int MAX_ROWS   = MAX_ROWS_DEF,
   parameter int CHANNELS   = CHANNELS_DEF,
   parameter int COEF_FRAC  = COEF_FRAC_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ic2d_req_type     req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ic2d_rsp_type     rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [2:0]       csr_index,
   input  logic [CFG_W-1:0] csr_data
);

   localparam int LINES = (MAX_KERNEL > 1) ? MAX_KERNEL - 1 : 1;
   localparam int NR    = MAX_KERNEL - 1;
   localparam int KW    = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
   localparam int CW    = $clog2(MAX_COLS);
   localparam int RW    = $clog2(MAX_ROWS);
   localparam int DW    = (CW > RW) ? CW : RW;
   localparam int SW    = (LINES > 1) ? $clog2(LINES) : 1;
   localparam int AW    = SW + CW;
   localparam int DEPTH = 2 ** AW;
   localparam int PIX_W = 8 * CHANNELS;
   localparam int CLW   = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;
   localparam int RLW   = (RW + 1 > CFG_W) ? RW + 1 : CFG_W;

   // Registers.
   logic [CFG_W-1:0] frame_cols_ff, frame_rows_ff, out_rows_ff, out_cols_ff;
   logic [2:0]       kernel_size_ff, stride_ff;

   // Controller.
   ic2d_state_type    state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;

   // Position and window state.
   logic [CW-1:0]            col_pos_ff;
   logic [RW-1:0]            row_pos_ff;
   logic [SW-1:0]            slot_ff;
   logic [PIX_W-1:0]         pix_ff;
   logic [PIX_W-1:0]         col_buf_ff [LINES];
   logic signed [COEF_W-1:0] kern_ff [MAX_KERNEL][MAX_KERNEL];
   logic signed [ACC_W-1:0]  total_ff [CHANNELS];
   logic [DW-1:0]            orow_ff, ocol_ff;
   logic                     fend_ff;
   logic                     rsp_valid_ff;
   ic2d_rsp_type             rsp_data_ff;

   // Control outputs of the controller.
   logic              div_start, buf_load, ram_we, pos_update;
   logic              total_clear, total_add, rsp_load;
   ic2d_cell_ctl_type cell_ctl;

   // Derived limits.
   logic [2:0]     k_lim, s_lim, base;
   logic [CLW-1:0] cols_lim;
   logic [RLW-1:0] rows_lim;

   // Stride dividers.
   logic          row_busy, col_busy;
   logic [DW-1:0] row_quo, col_quo, row_div_in, col_div_in;
   logic [2:0]    row_rem, col_rem;

   // Line store access.
   logic [SW+1:0]    rd_slot_sum;
   logic [SW-1:0]    rd_slot;
   logic [AW-1:0]    rd_addr, wr_addr;
   logic [PIX_W-1:0] rd_data;
   logic [PIX_W-1:0] req_pix;

   // Window decision.
   logic row_ok, col_ok, emit_now, col_last, row_last;
   logic coef_wr, req_acc;

   logic [CHANNELS-1:0][ACC_W-1:0] cell_acc [MAX_KERNEL];
   logic [7:0]                     res_ch [3];

   // Effective register values.
   always_comb begin
      if (kernel_size_ff == 3'd0) begin
         k_lim = 3'd1;
      end else if (kernel_size_ff > 3'(MAX_KERNEL)) begin
         k_lim = 3'(MAX_KERNEL);
      end else begin
         k_lim = kernel_size_ff;
      end
      s_lim = (stride_ff == 3'd0) ? 3'd1 : stride_ff;
      if (frame_cols_ff == '0) begin
         cols_lim = CLW'(1);
      end else if (CLW'(frame_cols_ff) > CLW'(MAX_COLS)) begin
         cols_lim = CLW'(MAX_COLS);
      end else begin
         cols_lim = CLW'(frame_cols_ff);
      end
      if (frame_rows_ff == '0) begin
         rows_lim = RLW'(1);
      end else if (RLW'(frame_rows_ff) > RLW'(MAX_ROWS)) begin
         rows_lim = RLW'(MAX_ROWS);
      end else begin
         rows_lim = RLW'(frame_rows_ff);
      end
      base = 3'(MAX_KERNEL) - k_lim;
   end

   // Configuration writes.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_cols_ff  <= FRAME_COLS_RST;
         frame_rows_ff  <= FRAME_ROWS_RST;
         out_rows_ff    <= OUT_ROWS_RST;
         out_cols_ff    <= OUT_COLS_RST;
         kernel_size_ff <= KERNEL_SIZE_RST;
         stride_ff      <= STRIDE_RST;
      end else if (csr_valid && csr_ready) begin
         case (ic2d_csr_type'(csr_index))
            CSR_FRAME_COLS:  frame_cols_ff  <= csr_data;
            CSR_FRAME_ROWS:  frame_rows_ff  <= csr_data;
            CSR_OUT_ROWS:    out_rows_ff    <= csr_data;
            CSR_OUT_COLS:    out_cols_ff    <= csr_data;
            CSR_KERNEL_SIZE: kernel_size_ff <= csr_data[2:0];
            CSR_STRIDE:      stride_ff      <= csr_data[2:0];
            default: ;
         endcase
      end
   end

   // Request pixel, channels beyond the input's three read as zero.
   for (genvar n = 0; n < CHANNELS; n++) begin : g_pix
      if (n == 0) begin : g_c0
         assign req_pix[7:0] = req_data.pixel_ch0;
      end else if (n == 1) begin : g_c1
         assign req_pix[15:8] = req_data.pixel_ch1;
      end else if (n == 2) begin : g_c2
         assign req_pix[23:16] = req_data.pixel_ch2;
      end else begin : g_cz
         assign req_pix[8*n +: 8] = 8'd0;
      end
   end

   assign req_acc = req_valid && req_ready;
   assign coef_wr = req_acc && (req_data.req_type == REQ_COEF)
                    && (row_pos_ff == '0) && (col_pos_ff == '0)
                    && (req_data.coef_row < 3'(MAX_KERNEL))
                    && (req_data.coef_col < 3'(MAX_KERNEL));

   // Row and column of the window's top-left corner in the frame.
   assign row_div_in = DW'(row_pos_ff + RW'(1) - RW'(k_lim));
   assign col_div_in = DW'(col_pos_ff + CW'(1) - CW'(k_lim));

   ic2d_div #(.DW(DW)) u_row_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (row_div_in),
      .divisor   (s_lim),
      .busy      (row_busy),
      .quotient  (row_quo),
      .remainder (row_rem)
   );

   ic2d_div #(.DW(DW)) u_col_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (col_div_in),
      .divisor   (s_lim),
      .busy      (col_busy),
      .quotient  (col_quo),
      .remainder (col_rem)
   );

   // Line store: one read per cycle walks the stored rows of this column.
   always_comb begin
      rd_slot_sum = (SW+2)'(slot_ff) + (SW+2)'(step_ff);
      if (rd_slot_sum >= (SW+2)'(LINES)) begin
         rd_slot_sum = rd_slot_sum - (SW+2)'(LINES);
      end
      rd_slot = rd_slot_sum[SW-1:0];
      rd_addr = AW'({rd_slot, col_pos_ff});
      wr_addr = AW'({slot_ff, col_pos_ff});
   end

   ic2d_ram #(.WIDTH(PIX_W), .DEPTH(DEPTH)) u_line_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (wr_addr),
      .wr_data (pix_ff),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Window decision for the current pixel.
   always_comb begin
      row_ok   = RLW'(row_pos_ff) + RLW'(1) >= RLW'(k_lim);
      col_ok   = CLW'(col_pos_ff) + CLW'(1) >= CLW'(k_lim);
      emit_now = row_ok && col_ok && (row_rem == 3'd0) && (col_rem == 3'd0)
                 && (CMP_W'(row_quo) < CMP_W'(out_rows_ff))
                 && (CMP_W'(col_quo) < CMP_W'(out_cols_ff));
      col_last = CLW'(col_pos_ff) + CLW'(1) >= cols_lim;
      row_last = RLW'(row_pos_ff) + RLW'(1) >= rows_lim;
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_data.req_type == REQ_PIXEL) begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (!row_busy && !col_busy) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            if (step_ff == STEP_W'(NR)) begin
               state_in = ST_SHIFT;
            end
         end
         ST_SHIFT: state_in = emit_now ? ST_MAC : ST_IDLE;
         ST_MAC: begin
            if (step_ff == k_lim - 3'd1) begin
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            if (step_ff == STEP_W'(MAX_KERNEL - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      step_in = (state_in != state_ff) ? '0 : step_ff + 1'b1;
   end

   // Controller outputs.
   always_comb begin
      req_ready   = 1'b0;
      div_start   = 1'b0;
      buf_load    = 1'b0;
      ram_we      = 1'b0;
      pos_update  = 1'b0;
      total_clear = 1'b0;
      total_add   = 1'b0;
      rsp_load    = 1'b0;
      cell_ctl    = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            div_start = req_valid && req_data.req_type == REQ_PIXEL;
         end
         ST_READ: buf_load = step_ff != '0;
         ST_SHIFT: begin
            cell_ctl.shift     = 1'b1;
            cell_ctl.mac_clear = 1'b1;
            ram_we             = 1'b1;
            pos_update         = 1'b1;
            total_clear        = 1'b1;
         end
         ST_MAC: cell_ctl.mac_en = 1'b1;
         ST_SUM: begin
            cell_ctl.sum_shift = 1'b1;
            total_add          = 1'b1;
         end
         ST_DONE: rsp_load = !rsp_valid_ff || rsp_ready;
         default: ;
      endcase
   end

   // Controller, position counters and kernel store.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         step_ff    <= '0;
         col_pos_ff <= '0;
         row_pos_ff <= '0;
         slot_ff    <= '0;
         for (int i = 0; i < MAX_KERNEL; i++) begin
            for (int j = 0; j < MAX_KERNEL; j++) begin
               kern_ff[i][j] <= '0;
            end
         end
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         if (coef_wr) begin
            kern_ff[req_data.coef_row[KW-1:0]][req_data.coef_col[KW-1:0]] <=
               req_data.coef_value;
         end
         if (pos_update) begin
            if (col_last) begin
               col_pos_ff <= '0;
               if (row_last) begin
                  row_pos_ff <= '0;
                  slot_ff    <= '0;
               end else begin
                  row_pos_ff <= row_pos_ff + 1'b1;
                  slot_ff    <= (slot_ff == SW'(LINES - 1)) ? '0 : slot_ff + 1'b1;
               end
            end else begin
               col_pos_ff <= col_pos_ff + 1'b1;
            end
         end
      end
   end

   // Request pixel, column of older rows, and the coordinates of a result.
   always_ff @(posedge clock) begin
      if (div_start) begin
         pix_ff <= req_pix;
      end
      if (buf_load) begin
         col_buf_ff[SW'(step_ff - 1'b1)] <= rd_data;
      end
      if (pos_update) begin
         orow_ff <= row_quo;
         ocol_ff <= col_quo;
         fend_ff <= (CMP_W'(row_quo) + CMP_W'(1) == CMP_W'(out_rows_ff))
                    && (CMP_W'(col_quo) + CMP_W'(1) == CMP_W'(out_cols_ff));
      end
   end

   // Chain of row cells.
   for (genvar i = 0; i < MAX_KERNEL; i++) begin : g_cell
      logic [PIX_W-1:0]         shift_pix;
      logic [SEL_W-1:0]         col_sel;
      logic [2:0]               fi;
      logic                     row_used;
      logic signed [COEF_W-1:0] coef;
      logic [CHANNELS-1:0][ACC_W-1:0] acc_in;

      if (i < NR) begin : g_old
         assign shift_pix = col_buf_ff[i];
      end else begin : g_new
         assign shift_pix = pix_ff;
      end

      if (i == 0) begin : g_head
         assign acc_in = '0;
      end else begin : g_link
         assign acc_in = cell_acc[i-1];
      end

      assign col_sel  = base + step_ff;
      assign fi       = 3'(i) - base;
      assign row_used = 3'(i) >= base;
      assign coef     = row_used ? kern_ff[fi[KW-1:0]][step_ff[KW-1:0]] : '0;

      ic2d_cell #(.MAX_KERNEL(MAX_KERNEL), .CHANNELS(CHANNELS)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (cell_ctl),
         .shift_pix (shift_pix),
         .col_sel   (col_sel),
         .coef      (coef),
         .row_used  (row_used),
         .acc_in    (acc_in),
         .acc_out   (cell_acc[i])
      );
   end

   // Final sums collected from the end of the chain, then clamped.
   for (genvar n = 0; n < 3; n++) begin : g_out
      if (n < CHANNELS) begin : g_live
         logic signed [ACC_W-1:0] q;

         always_ff @(posedge clock) begin
            if (total_clear) begin
               total_ff[n] <= '0;
            end else if (total_add) begin
               total_ff[n] <= total_ff[n] + $signed(cell_acc[MAX_KERNEL-1][n]);
            end
         end

         assign q = total_ff[n] >>> COEF_FRAC;

         always_comb begin
            if (total_ff[n] < 0) begin
               res_ch[n] = 8'd0;
            end else if (q > ACC_W'(PIX_MAX)) begin
               res_ch[n] = 8'(PIX_MAX);
            end else begin
               res_ch[n] = q[7:0];
            end
         end
      end else begin : g_zero
         assign res_ch[n] = 8'd0;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (rsp_load) begin
         rsp_data_ff.out_ch0   <= res_ch[0];
         rsp_data_ff.out_ch1   <= res_ch[1];
         rsp_data_ff.out_ch2   <= res_ch[2];
         rsp_data_ff.out_row   <= orow_ff[9:0];
         rsp_data_ff.out_col   <= ocol_ff[9:0];
         rsp_data_ff.frame_end <= fend_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A coefficient request leaves the frame position untouched.
   assert property (@(posedge clock) disable iff (reset)
      req_acc && req_data.req_type == REQ_COEF |=>
         $stable(row_pos_ff) && $stable(col_pos_ff))
      else $error("coefficient request moved the frame position");

   // The stride dividers have finished before the line store is walked.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_READ |-> !row_busy && !col_busy)
      else $error("line store read started before the dividers finished");

   // A new result is only loaded at the end of the summing sequence.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_DONE)
      else $error("result raised outside the completion state");

endmodule

FILE: test/ic2d_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ic2d_checker: scoreboard of the 2D convolution core
// Watches the request, response and register channels, keeps its own copy of
// the line stores, window, kernel and registers, and compares every response
// with the oldest predicted filter result.
// ----------------------------------------------------------------------------
module ic2d_checker import ic2d_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  ic2d_req_type     req_data,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  ic2d_rsp_type     rsp_data,
   input  logic             csr_valid,
   input  logic             csr_ready,
   input  logic [2:0]       csr_index,
   input  logic [CFG_W-1:0] csr_data,
   output int               failures,
   output int               pending,
   output int               results
);

   localparam int KMAX  = MAX_KERNEL_DEF;
   localparam int WMAX  = MAX_COLS_DEF;
   localparam int LINES = KMAX - 1;

   // Mirror of the core's storage and registers.
   logic [23:0]        line_mem [LINES*WMAX];
   logic [23:0]        win      [KMAX][KMAX];
   logic signed [15:0] kern     [KMAX][KMAX];
   int unsigned        row_at, col_at;
   logic [CFG_W-1:0]   frame_cols, frame_rows, out_rows, out_cols;
   logic [2:0]         kernel_size, stride;

   ic2d_rsp_type filtered_q [$];

   assign pending = filtered_q.size();

   function automatic logic [7:0] clamp_pixel(input longint acc);
      longint q;
      q = acc >>> COEF_FRAC_DEF;
      if (acc < 0) return 8'd0;
      if (q > PIX_MAX) return 8'd255;
      return q[7:0];
   endfunction

   // Advance the mirror by one accepted request and queue any filter result.
   task automatic convolve_request(input ic2d_req_type rq);
      int unsigned  k, s, cols, rows, slot, dr, dc, orow, ocol, base;
      logic [23:0]  pix;
      longint       acc;
      ic2d_rsp_type res;
      logic [7:0]   chans [3];
      if (rq.req_type == REQ_COEF) begin
         if (row_at == 0 && col_at == 0 && rq.coef_row < KMAX && rq.coef_col < KMAX)
            kern[rq.coef_row][rq.coef_col] = rq.coef_value;
         return;
      end
      k    = (kernel_size == 0) ? 1 : ((kernel_size > KMAX) ? KMAX : kernel_size);
      s    = (stride == 0) ? 1 : stride;
      cols = (frame_cols == 0) ? 1 : ((frame_cols > WMAX) ? WMAX : frame_cols);
      rows = (frame_rows == 0) ? 1 : ((frame_rows > MAX_ROWS_DEF) ? MAX_ROWS_DEF : frame_rows);
      pix  = {rq.pixel_ch2, rq.pixel_ch1, rq.pixel_ch0};

      // Shift the window left and pull the new column from the line stores.
      for (int i = 0; i < KMAX; i++)
         for (int j = 0; j < KMAX - 1; j++)
            win[i][j] = win[i][j+1];
      for (int i = 0; i < KMAX - 1; i++) begin
         slot = ((row_at % LINES) + LINES - (KMAX - 1 - i)) % LINES;
         win[i][KMAX-1] = line_mem[slot*WMAX + col_at];
      end
      win[KMAX-1][KMAX-1] = pix;
      line_mem[(row_at % LINES)*WMAX + col_at] = pix;

      // A result is due when this pixel closes a strided window in range.
      if (row_at + 1 >= k && col_at + 1 >= k) begin
         dr = row_at + 1 - k;
         dc = col_at + 1 - k;
         if (dr % s == 0 && dc % s == 0) begin
            orow = dr / s;
            ocol = dc / s;
            if (orow < out_rows && ocol < out_cols) begin
               base = KMAX - k;
               for (int n = 0; n < 3; n++) begin
                  acc = 0;
                  for (int fi = 0; fi < k; fi++)
                     for (int fj = 0; fj < k; fj++)
                        acc += longint'(win[base+fi][base+fj][8*n +: 8]) *
                               longint'(kern[fi][fj]);
                  chans[n] = clamp_pixel(acc);
               end
               res.out_ch0   = chans[0];
               res.out_ch1   = chans[1];
               res.out_ch2   = chans[2];
               res.out_row   = orow[9:0];
               res.out_col   = ocol[9:0];
               res.frame_end = (orow + 1 == out_rows && ocol + 1 == out_cols);
               filtered_q.push_back(res);
            end
         end
      end

      if (col_at + 1 >= cols) begin
         col_at = 0;
         row_at = (row_at + 1 >= rows) ? 0 : row_at + 1;
      end else begin
         col_at = col_at + 1;
      end
   endtask

   // Sample every channel at the rising edge.
   always @(posedge clock) begin
      ic2d_rsp_type want;
      if (reset) begin
         for (int i = 0; i < KMAX; i++)
            for (int j = 0; j < KMAX; j++) begin
               win[i][j]  = '0;
               kern[i][j] = '0;
            end
         foreach (line_mem[i]) line_mem[i] = '0;
         row_at      = 0;
         col_at      = 0;
         frame_cols  = FRAME_COLS_RST;
         frame_rows  = FRAME_ROWS_RST;
         out_rows    = OUT_ROWS_RST;
         out_cols    = OUT_COLS_RST;
         kernel_size = KERNEL_SIZE_RST;
         stride      = STRIDE_RST;
         filtered_q.delete();
         failures    = 0;
         results     = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (ic2d_csr_type'(csr_index))
               CSR_FRAME_COLS:  frame_cols  = csr_data;
               CSR_FRAME_ROWS:  frame_rows  = csr_data;
               CSR_OUT_ROWS:    out_rows    = csr_data;
               CSR_OUT_COLS:    out_cols    = csr_data;
               CSR_KERNEL_SIZE: kernel_size = csr_data[2:0];
               CSR_STRIDE:      stride      = csr_data[2:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            convolve_request(req_data);
         if (rsp_valid && rsp_ready) begin
            results++;
            if (filtered_q.size() == 0) begin
               failures++;
               $display("%0t: unexpected response %h", $time, rsp_data);
            end else begin
               want = filtered_q.pop_front();
               if (want.out_ch0 !== rsp_data.out_ch0 || want.out_ch1 !== rsp_data.out_ch1 ||
                   want.out_ch2 !== rsp_data.out_ch2 || want.out_row !== rsp_data.out_row ||
                   want.out_col !== rsp_data.out_col ||
                   want.frame_end !== rsp_data.frame_end) begin
                  failures++;
                  $display("%0t: mismatch expected ch %0d/%0d/%0d row %0d col %0d end %0b",
                           $time, want.out_ch0, want.out_ch1, want.out_ch2,
                           want.out_row, want.out_col, want.frame_end);
                  $display("%0t:          actual   ch %0d/%0d/%0d row %0d col %0d end %0b",
                           $time, rsp_data.out_ch0, rsp_data.out_ch1, rsp_data.out_ch2,
                           rsp_data.out_row, rsp_data.out_col, rsp_data.frame_end);
               end
            end
         end
      end
   end

endmodule

FILE: test/tb_image_convolution_2d_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_image_convolution_2d_core: stimulus and verdict for the convolution core
// Runs a series of small padded frames with varied kernel sizes, strides,
// output sizes and kernels, with bursty requests and a stalling receiver.
// ----------------------------------------------------------------------------
module tb_image_convolution_2d_core import ic2d_pkg::*; ();

   localparam int SETTLE     = 60;
   localparam int LIMIT      = 800000;
   localparam int PRIME_COLS = 12;
   localparam int TARGET     = 1100;

   logic             clock;
   logic             reset;
   logic             req_valid, req_ready;
   ic2d_req_type     req_data;
   logic             rsp_valid, rsp_ready;
   ic2d_rsp_type     rsp_data;
   logic             csr_valid, csr_ready;
   logic [2:0]       csr_index;
   logic [CFG_W-1:0] csr_data;
   int               failures, pending, results;
   int               cycles, burst_left, pixels, frames, requests;
   bit               no_gaps;

   image_convolution_2d_core u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   ic2d_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data),
      .failures(failures), .pending(pending), .results(results)
   );

   always begin
      clock = 1'b1; #10;
      clock = 1'b0; #10;
   end

   // Cycle count and run guard.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("** image_convolution_2d_core: FAILED **");
         $finish;
      end
   end

   // Receiver: always ready, random stalls, or a fixed stall pattern.
   always @(posedge clock) begin
      case ((cycles >> 9) % 3)
         0:       rsp_ready <= 1'b1;
         1:       rsp_ready <= ($urandom_range(0, 9) < 6);
         default: rsp_ready <= ((cycles % 7) < 3);
      endcase
   end

   // Drive one request; bursts of random length separated by random gaps.
   task automatic push_request(input ic2d_req_type rq);
      if (!no_gaps && burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = $urandom_range(1, 24);
      end
      req_valid <= 1'b1;
      req_data  <= rq;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (burst_left > 0) burst_left--;
      requests++;
   endtask

   // Hold off until every result has come back and the core has settled.
   task automatic drain_core();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_csr(input ic2d_csr_type idx, input int value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value[CFG_W-1:0];
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic signed [15:0] pick_coef();
      case ($urandom_range(0, 9))
         0:       return 16'sh8000;
         1:       return 16'sh7fff;
         2, 3:    return 16'($urandom);
         default: return 16'($signed($urandom_range(0, 640)) - 320);
      endcase
   endfunction

   function automatic logic [7:0] pick_sample();
      case ($urandom_range(0, 7))
         0:       return 8'd0;
         1:       return 8'd255;
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic send_coef(input int r, input int c, input logic signed [15:0] v);
      ic2d_req_type rq;
      rq            = ic2d_req_type'($urandom);
      rq.req_type   = REQ_COEF;
      rq.coef_row   = r[2:0];
      rq.coef_col   = c[2:0];
      rq.coef_value = v;
      push_request(rq);
   endtask

   // Load a full kernel, plus requests that fall outside the kernel store.
   task automatic load_kernel();
      for (int r = 0; r < 5; r++)
         for (int c = 0; c < 5; c++)
            send_coef(r, c, pick_coef());
      send_coef($urandom_range(5, 7), $urandom_range(0, 7), pick_coef());
      send_coef($urandom_range(0, 4), $urandom_range(5, 7), pick_coef());
   endtask

   // One padded frame; a coefficient request inside it must be ignored.
   task automatic run_frame(input int fc, input int fr, input int orows, input int ocols,
                            input int ksz, input int strd, input bit reload);
      int           w, h, stray, hold;
      ic2d_req_type rq;
      w     = (fc == 0) ? 1 : fc;
      h     = (fr == 0) ? 1 : fr;
      stray = $urandom_range(1, w*h);
      hold  = $urandom_range(1, w*h);
      drain_core();
      write_csr(CSR_FRAME_COLS, fc);
      write_csr(CSR_FRAME_ROWS, fr);
      write_csr(CSR_OUT_ROWS, orows);
      write_csr(CSR_OUT_COLS, ocols);
      write_csr(CSR_KERNEL_SIZE, ksz);
      write_csr(CSR_STRIDE, strd);
      no_gaps = ($urandom_range(0, 3) == 0);
      if (reload) load_kernel();
      for (int p = 0; p < w*h; p++) begin
         if (p == stray) send_coef(0, 0, 16'sh7fff);
         if (p == hold && $urandom_range(0, 3) == 0) drain_core();
         rq           = ic2d_req_type'({$urandom, $urandom});
         rq.req_type  = REQ_PIXEL;
         rq.pixel_ch0 = pick_sample();
         rq.pixel_ch1 = pick_sample();
         rq.pixel_ch2 = pick_sample();
         push_request(rq);
         pixels++;
      end
      frames++;
   endtask

   initial begin
      int fc, fr, ksz, strd, reach_r, reach_c;
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_data   = '0;
      rsp_ready  = 1'b0;
      csr_valid  = 1'b0;
      csr_index  = CSR_FRAME_COLS;
      csr_data   = '0;
      cycles     = 0;
      burst_left = 0;
      pixels     = 0;
      frames     = 0;
      requests   = 0;
      no_gaps    = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Register extremes written while idle, then overwritten per frame.
      write_csr(CSR_FRAME_COLS, 2047);
      write_csr(CSR_FRAME_ROWS, 2047);
      write_csr(CSR_OUT_ROWS, 1024);
      write_csr(CSR_OUT_COLS, 1024);
      write_csr(CSR_KERNEL_SIZE, 7);
      write_csr(CSR_STRIDE, 0);

      // First frame fills every line store entry any later frame will read.
      run_frame(PRIME_COLS, 4, 1024, 1024, 3, 1, 1'b1);
      // Directed corners: single pixel, one column, largest kernel, big stride.
      run_frame(1, 1, 1, 1, 0, 0, 1'b0);
      run_frame(0, 0, 1, 1, 1, 7, 1'b1);
      run_frame(1, 6, 8, 1, 1, 1, 1'b0);
      run_frame(PRIME_COLS, 6, 2, 8, 5, 1, 1'b1);
      run_frame(PRIME_COLS, 7, 2, 2, 6, 5, 1'b0);
      run_frame(PRIME_COLS, 5, 0, 4, 2, 2, 1'b0);
      run_frame(8, 4, 1024, 1024, 3, 6, 1'b0);

      // Random frames.
      while (requests < TARGET) begin
         fc      = $urandom_range(0, PRIME_COLS);
         fr      = $urandom_range(0, 9);
         ksz     = $urandom_range(0, 7);
         strd    = $urandom_range(0, 7);
         reach_r = (fr > 4) ? fr : 4;
         reach_c = (fc > 4) ? fc : 4;
         run_frame(fc, fr,
                   ($urandom_range(0, 9) == 0) ? 1024 : $urandom_range(0, reach_r),
                   ($urandom_range(0, 9) == 0) ? 1024 : $urandom_range(0, reach_c),
                   ksz, strd, $urandom_range(0, 1));
      end
      drain_core();

      $display("Ran %0d frames, %0d requests of which %0d pixels; %0d results checked.",
               frames, requests, pixels, results);
      $display("Kernel sizes 1 to 5, strides 1 to 7, clipped and unreachable output sizes.");
      if (failures == 0 && pending == 0)
         $display("** image_convolution_2d_core: PASSED **");
      else
         $display("** image_convolution_2d_core: FAILED **");
      $finish;
   end

endmodule

FILE: sim.f
rtl/ic2d_pkg.sv
rtl/ic2d_ram.sv
rtl/ic2d_div.sv
rtl/ic2d_cell.sv
rtl/image_convolution_2d_core.sv
test/ic2d_checker.sv
test/tb_image_convolution_2d_core.sv
